>>> rtl/core/stu_pkg.sv
// Shared types, constants and a helper function for the stereo to surround upmixer.
`timescale 1ns / 1ps

package stu_pkg;

  // Default sample width and the number of pipeline stages from accept to strobe
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PIPE_LATENCY    = 5;

  // Gain formats: matrix gain Q0.15, output gain Q4.12
  localparam int MG_W      = 15;
  localparam int OG_W      = 16;
  localparam int MG_FRAC   = 15;
  localparam int OG_FRAC   = 12;
  localparam int PROD_FRAC = MG_FRAC + OG_FRAC;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 3;
  localparam int NUM_OUT    = 6;

  // Register reset values
  localparam logic              MIX_EN_RST   = 1'b1;
  localparam logic [MODE_W-1:0] MODE_RST     = 3'd0;
  localparam logic [OG_W-1:0]   OUT_GAIN_RST = 16'd4096;
  localparam logic [MG_W-1:0]   MTX_GAIN_RST = 15'd20675;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_MIXER_ENABLE = 2'd0,
    IDX_OUTPUT_MODE  = 2'd1,
    IDX_OUTPUT_GAIN  = 2'd2,
    IDX_MATRIX_GAIN  = 2'd3
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_2_2_0 = 3'd0,
    MODE_2_0_0 = 3'd1,
    MODE_2_2_1 = 3'd2,
    MODE_3_2_0 = 3'd3,
    MODE_3_2_1 = 3'd4
  } mode_t;

  // Channel order within a mask: L, R, C, Ls, Rs, LFE
  localparam int CH_FL  = 0;
  localparam int CH_FR  = 1;
  localparam int CH_C   = 2;
  localparam int CH_SL  = 3;
  localparam int CH_SR  = 4;
  localparam int CH_LFE = 5;

  localparam logic [NUM_OUT-1:0] MASK_2_2_0 = 6'h1B;
  localparam logic [NUM_OUT-1:0] MASK_2_0_0 = 6'h03;
  localparam logic [NUM_OUT-1:0] MASK_2_2_1 = 6'h3B;
  localparam logic [NUM_OUT-1:0] MASK_3_2_0 = 6'h1F;
  localparam logic [NUM_OUT-1:0] MASK_3_2_1 = 6'h3F;

  typedef struct packed {
    logic              mix_en;
    logic [MODE_W-1:0] mode;
    logic [OG_W-1:0]   out_gain;
    logic [MG_W-1:0]   mtx_gain;
  } cfg_t;

  // Control that travels alongside the data
  typedef struct packed {
    logic              valid;
    logic              mix_en;
    logic [MODE_W-1:0] mode;
  } ctrl_t;

  // Unused mode codes fall back to 2_2_0
  function automatic logic [NUM_OUT-1:0] mode_mask(input logic [MODE_W-1:0] code);
    logic [NUM_OUT-1:0] m;
    unique case (code)
      MODE_2_2_0: m = MASK_2_2_0;
      MODE_2_0_0: m = MASK_2_0_0;
      MODE_2_2_1: m = MASK_2_2_1;
      MODE_3_2_0: m = MASK_3_2_0;
      MODE_3_2_1: m = MASK_3_2_1;
      default:    m = MASK_2_2_0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/stereo_to_surround_upmixer_unit.sv
// Top level of the stereo to 5.1 surround upmixer.
`timescale 1ns / 1ps

// Pipeline: an accepted transaction passes through five register stages (sum,
//   magnitude, matrix gain multiply, output gain multiply, round/saturate/mask)
//   before its result is strobed on out_valid.
// Throughput: one frame per cycle; the pipeline never stalls, so busy stays low.
// Reset (rst_n low, synchronous): clears all valid bits and loads the register defaults
//   (mixer enabled, mode 2_2_0, output gain 1.0, matrix gain about -4 dB).
module stereo_to_surround_upmixer_unit
  import stu_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input frame
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  // Result frame
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_front_left,
  output logic signed [SAMPLE_BITS-1:0] out_front_right,
  output logic signed [SAMPLE_BITS-1:0] out_center_out,
  output logic signed [SAMPLE_BITS-1:0] out_surround_left,
  output logic signed [SAMPLE_BITS-1:0] out_surround_right,
  output logic signed [SAMPLE_BITS-1:0] out_lfe_out,
  // Configuration writes
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  cfg_t                          cfg;
  ctrl_t                         pipe_ctrl;
  logic                          pipe_neg;
  logic [SAMPLE_BITS+31:0]       pipe_prod;
  logic signed [SAMPLE_BITS-1:0] pipe_left;
  logic signed [SAMPLE_BITS-1:0] pipe_right;
  logic                          in_accept;

  // Every stage advances each cycle and the receiver cannot hold results off, so a
  // frame can always enter.
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // Register file: the pipeline reads gains live and captures mode at accept. The user
  // must change them only while no transaction is in flight; the block does not check.
  stu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Stages one to four: add left and right, take sign and magnitude, then apply the
  // matrix gain and the output gain, one multiply per stage.
  stu_mix_pipe #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .left_in  (in_left_in),
    .right_in (in_right_in),
    .cfg      (cfg),
    .ctrl     (pipe_ctrl),
    .neg      (pipe_neg),
    .prod     (pipe_prod),
    .left_q   (pipe_left),
    .right_q  (pipe_right)
  );

  // Stage five: round half away from zero, saturate, apply the mode mask or bypass,
  // and hold the frame in the output registers for its strobe cycle.
  stu_out_stage #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (pipe_ctrl),
    .neg                (pipe_neg),
    .prod               (pipe_prod),
    .left_q             (pipe_left),
    .right_q            (pipe_right),
    .out_valid          (out_valid),
    .out_front_left     (out_front_left),
    .out_front_right    (out_front_right),
    .out_center_out     (out_center_out),
    .out_surround_left  (out_surround_left),
    .out_surround_right (out_surround_right),
    .out_lfe_out        (out_lfe_out)
  );

`ifndef SYNTHESIS
  a_accept_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##PIPE_LATENCY out_valid)
    else $error("accepted transaction produced no result strobe");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |-> ##PIPE_LATENCY !out_valid)
    else $error("result strobe without an accepted transaction");

  a_strobe_matches_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_ctrl.valid |=> out_valid)
    else $error("final stage dropped a transaction");
`endif

endmodule

>>> rtl/core/stu_cfg_regs.sv
// Configuration register file of the upmixer.
`timescale 1ns / 1ps

module stu_cfg_regs
  import stu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        IDX_MIXER_ENABLE: cfg_nxt.mix_en   = cfg_wdata[0];
        IDX_OUTPUT_MODE:  cfg_nxt.mode     = cfg_wdata[MODE_W-1:0];
        IDX_OUTPUT_GAIN:  cfg_nxt.out_gain = cfg_wdata[OG_W-1:0];
        IDX_MATRIX_GAIN:  cfg_nxt.mtx_gain = cfg_wdata[MG_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mix_en   <= MIX_EN_RST;
      cfg_r.mode     <= MODE_RST;
      cfg_r.out_gain <= OUT_GAIN_RST;
      cfg_r.mtx_gain <= MTX_GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/stu_mix_pipe.sv
// Sum, magnitude and two gain multiply stages of the upmixer pipeline.
`timescale 1ns / 1ps

module stu_mix_pipe
  import stu_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  cfg_t                          cfg,
  output ctrl_t                         ctrl,
  output logic                          neg,
  output logic [SAMPLE_BITS+31:0]       prod,
  output logic signed [SAMPLE_BITS-1:0] left_q,
  output logic signed [SAMPLE_BITS-1:0] right_q
);

  localparam int SUM_W = SAMPLE_BITS + 1;
  localparam int P1_W  = SUM_W + MG_W;
  localparam int P2_W  = P1_W + OG_W;

  // Stage 1: snapshot control, add
  ctrl_t                   c1_r, c1_nxt;
  logic signed [SUM_W-1:0] sum1_r, sum1_nxt;
  logic signed [SAMPLE_BITS-1:0] l1_r, r1_r;
  // Stage 2: sign and magnitude
  ctrl_t                   c2_r;
  logic                    neg2_r;
  logic [SUM_W-1:0]        mag2_r, mag2_nxt;
  logic signed [SAMPLE_BITS-1:0] l2_r, r2_r;
  // Stage 3: times matrix gain
  ctrl_t                   c3_r;
  logic                    neg3_r;
  logic [P1_W-1:0]         p1_r, p1_nxt;
  logic signed [SAMPLE_BITS-1:0] l3_r, r3_r;
  // Stage 4: times output gain
  ctrl_t                   c4_r;
  logic                    neg4_r;
  logic [P2_W-1:0]         p2_r, p2_nxt;
  logic signed [SAMPLE_BITS-1:0] l4_r, r4_r;

  always_comb begin
    c1_nxt.valid  = in_valid;
    c1_nxt.mix_en = cfg.mix_en;
    c1_nxt.mode   = cfg.mode;
    sum1_nxt      = SUM_W'(left_in) + SUM_W'(right_in);
    mag2_nxt      = sum1_r[SUM_W-1] ? SUM_W'(-sum1_r) : SUM_W'(sum1_r);
    p1_nxt        = P1_W'(mag2_r) * P1_W'(cfg.mtx_gain);
    p2_nxt        = P2_W'(p1_r) * P2_W'(cfg.out_gain);
  end

  // Valid bits clear on reset; payload advances every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0;
      c2_r.valid <= 1'b0;
      c3_r.valid <= 1'b0;
      c4_r.valid <= 1'b0;
    end else begin
      c1_r.valid <= c1_nxt.valid;
      c2_r.valid <= c1_r.valid;
      c3_r.valid <= c2_r.valid;
      c4_r.valid <= c3_r.valid;
    end

    c1_r.mix_en <= c1_nxt.mix_en;
    c1_r.mode   <= c1_nxt.mode;
    sum1_r      <= sum1_nxt;
    l1_r        <= left_in;
    r1_r        <= right_in;

    c2_r.mix_en <= c1_r.mix_en;
    c2_r.mode   <= c1_r.mode;
    neg2_r      <= sum1_r[SUM_W-1];
    mag2_r      <= mag2_nxt;
    l2_r        <= l1_r;
    r2_r        <= r1_r;

    c3_r.mix_en <= c2_r.mix_en;
    c3_r.mode   <= c2_r.mode;
    neg3_r      <= neg2_r;
    p1_r        <= p1_nxt;
    l3_r        <= l2_r;
    r3_r        <= r2_r;

    c4_r.mix_en <= c3_r.mix_en;
    c4_r.mode   <= c3_r.mode;
    neg4_r      <= neg3_r;
    p2_r        <= p2_nxt;
    l4_r        <= l3_r;
    r4_r        <= r3_r;
  end

  assign ctrl    = c4_r;
  assign neg     = neg4_r;
  assign prod    = p2_r;
  assign left_q  = l4_r;
  assign right_q = r4_r;

endmodule

>>> rtl/core/stu_out_stage.sv
// Rounding, saturation, channel masking and output registers of the upmixer.
`timescale 1ns / 1ps

module stu_out_stage
  import stu_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctrl_t                         ctrl,
  input  logic                          neg,
  input  logic [SAMPLE_BITS+31:0]       prod,
  input  logic signed [SAMPLE_BITS-1:0] left_q,
  input  logic signed [SAMPLE_BITS-1:0] right_q,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_front_left,
  output logic signed [SAMPLE_BITS-1:0] out_front_right,
  output logic signed [SAMPLE_BITS-1:0] out_center_out,
  output logic signed [SAMPLE_BITS-1:0] out_surround_left,
  output logic signed [SAMPLE_BITS-1:0] out_surround_right,
  output logic signed [SAMPLE_BITS-1:0] out_lfe_out
);

  localparam int P2_W = SAMPLE_BITS + 32;
  localparam int RND_W = P2_W + 1;
  localparam int Q_W  = RND_W - PROD_FRAC;
  localparam logic [RND_W-1:0] HALF = RND_W'(1) << (PROD_FRAC - 1);
  localparam logic [Q_W-1:0]   LIM  = Q_W'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] NEG_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [RND_W-1:0]       rnd;
  logic [Q_W-1:0]         q;
  logic                   over;
  logic [SAMPLE_BITS-1:0] val;
  logic [NUM_OUT-1:0]     mask;
  logic [SAMPLE_BITS-1:0] ch_nxt [NUM_OUT];
  logic [SAMPLE_BITS-1:0] ch_r   [NUM_OUT];
  logic                   valid_r;
  logic                   mix_r;

  always_comb begin
    rnd  = RND_W'(prod) + HALF;
    q    = rnd[RND_W-1:PROD_FRAC];
    over = (q >= LIM);
    if (neg) begin
      val = over ? NEG_MIN : SAMPLE_BITS'(-q[SAMPLE_BITS-1:0]);
    end else begin
      val = over ? POS_MAX : q[SAMPLE_BITS-1:0];
    end
    mask = mode_mask(ctrl.mode);
    for (int k = 0; k < NUM_OUT; k++) begin
      ch_nxt[k] = mask[k] ? val : '0;
    end
    // Bypass: stereo through, the rest silent
    if (!ctrl.mix_en) begin
      for (int k = 0; k < NUM_OUT; k++) begin
        ch_nxt[k] = '0;
      end
      ch_nxt[CH_FL] = left_q;
      ch_nxt[CH_FR] = right_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    mix_r <= ctrl.mix_en;
    for (int k = 0; k < NUM_OUT; k++) begin
      ch_r[k] <= ch_nxt[k];
    end
  end

  assign out_valid          = valid_r;
  assign out_front_left     = ch_r[CH_FL];
  assign out_front_right    = ch_r[CH_FR];
  assign out_center_out     = ch_r[CH_C];
  assign out_surround_left  = ch_r[CH_SL];
  assign out_surround_right = ch_r[CH_SR];
  assign out_lfe_out        = ch_r[CH_LFE];

`ifndef SYNTHESIS
  a_bypass_silent: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !mix_r |-> (ch_r[CH_C] == '0) && (ch_r[CH_SL] == '0) &&
                          (ch_r[CH_SR] == '0) && (ch_r[CH_LFE] == '0))
    else $error("bypass transaction has a non-zero extra channel");

  a_mix_fronts_equal: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && mix_r |-> ch_r[CH_FL] == ch_r[CH_FR])
    else $error("mixed transaction has unequal front channels");

  a_mix_centre: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && mix_r |-> (ch_r[CH_C] == '0) || (ch_r[CH_C] == ch_r[CH_FL]))
    else $error("mixed centre channel differs from the common value");
`endif

endmodule
